// ===== rtl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// shared types, character codes and helpers for the quoted string unescaper
// ----------------------------------------------------------------------------
package qsu_pkg;

   localparam int UNIT_WIDTH          = 16;
   localparam int DIGIT_WIDTH         = 8;
   localparam int HELD_MAX            = 3;
   localparam int RADIX_BITS          = 4;   // hex radix 16
   localparam int CSR_INDEX_WIDTH     = 4;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS         = 5;

   localparam logic [UNIT_WIDTH-1:0] CHAR_BACKSLASH = 16'h005C;
   localparam logic [UNIT_WIDTH-1:0] CHAR_U         = 16'h0075;
   localparam logic [UNIT_WIDTH-1:0] CHAR_X         = 16'h0078;
   localparam logic [UNIT_WIDTH-1:0] QUOTE_RESET    = 16'h0022;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUOTE_CHAR       = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNESCAPE_UNICODE = 4'd1;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_U    = 2'd1;
   localparam logic [1:0] KIND_X    = 2'd2;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] quote_char;
      logic                  unescape_unicode;
   } cfg_type;

   // one queue entry: a single result, or an escape echo
   typedef struct packed {
      logic                                 echo;
      logic [1:0]                           held_count;
      logic [HELD_MAX-1:0][DIGIT_WIDTH-1:0] held_digits;
      logic [UNIT_WIDTH-1:0]                unit;
      logic                                 unit_valid;
      logic                                 string_end;
      logic                                 unframed;
   } desc_type;

   function automatic logic hex_digit(input logic [UNIT_WIDTH-1:0] ch,
                                      output logic [RADIX_BITS-1:0] val);
      logic hit;
      hit = 1'b1;
      val = '0;
      if (ch >= 16'h0030 && ch <= 16'h0039) begin
         val = RADIX_BITS'(ch - 16'h0030);
      end else if (ch >= 16'h0061 && ch <= 16'h0066) begin
         val = RADIX_BITS'(ch - 16'h0061 + 16'd10);
      end else if (ch >= 16'h0041 && ch <= 16'h0046) begin
         val = RADIX_BITS'(ch - 16'h0041 + 16'd10);
      end else begin
         hit = 1'b0;
      end
      return hit;
   endfunction

endpackage

// ===== rtl/qsu_if.sv =====
// ----------------------------------------------------------------------------
// qsu interfaces
// valid/ready channels for input units, results and register writes
// ----------------------------------------------------------------------------
interface qsu_req_if import qsu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [UNIT_WIDTH-1:0] code_unit;
   logic                  is_first;
   logic                  is_final;
   modport source(output valid, code_unit, is_first, is_final, input ready);
   modport sink(input valid, code_unit, is_first, is_final, output ready);
endinterface

interface qsu_rsp_if import qsu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [UNIT_WIDTH-1:0] out_unit;
   logic                  unit_valid;
   logic                  run_end;
   logic                  string_end;
   logic                  unframed;
   modport source(output valid, out_unit, unit_valid, run_end, string_end, unframed,
                  input ready);
   modport sink(input valid, out_unit, unit_valid, run_end, string_end, unframed,
                output ready);
endinterface

interface qsu_csr_if import qsu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/qsu_front.sv =====
// ----------------------------------------------------------------------------
// qsu_front
// accepts code units, tracks framing and escape state, queues result groups
// ----------------------------------------------------------------------------
module qsu_front import qsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   qsu_req_if.sink     req,
   input  logic        queue_full,
   output logic        push,
   output desc_type    push_desc
);

   localparam logic [1:0] RES_NONE   = 2'd0;
   localparam logic [1:0] RES_SINGLE = 2'd1;
   localparam logic [1:0] RES_ECHO   = 2'd2;

   logic                                 decode_mode_ff, decode_mode_in;
   logic                                 in_escape_ff, in_escape_in;
   logic [1:0]                           escape_kind_ff, escape_kind_in;
   logic [1:0]                           held_count_ff, held_count_in;
   logic [UNIT_WIDTH-1:0]                hex_value_ff, hex_value_in;
   logic [HELD_MAX-1:0][DIGIT_WIDTH-1:0] held_digits_ff, held_digits_in;

   logic                  accept;
   logic [1:0]            res_kind;
   logic [UNIT_WIDTH-1:0] res_unit;
   logic                  res_valid;
   logic                  unframed;
   logic                  clr;
   logic                  is_hex;
   logic [RADIX_BITS-1:0] dval;
   logic                  is_quote;
   logic                  hex_done;
   logic [UNIT_WIDTH-1:0] cu;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign cu        = req.code_unit;
   assign is_quote  = (cu == cfg.quote_char);

   always_comb begin
      decode_mode_in = decode_mode_ff;
      in_escape_in   = in_escape_ff;
      escape_kind_in = escape_kind_ff;
      held_count_in  = held_count_ff;
      hex_value_in   = hex_value_ff;
      held_digits_in = held_digits_ff;
      res_kind       = RES_NONE;
      res_unit       = cu;
      res_valid      = 1'b1;
      unframed       = 1'b0;
      clr            = 1'b0;
      is_hex         = hex_digit(cu, dval);
      hex_done       = (escape_kind_ff == KIND_U) ? (held_count_ff == 2'd3)
                                                  : (held_count_ff != 2'd0);

      if (req.is_first) begin
         clr = 1'b1;
         if (is_quote && !req.is_final) begin
            decode_mode_in = 1'b1;
         end else begin
            decode_mode_in = 1'b0;
            res_kind       = RES_SINGLE;
         end
      end else if (decode_mode_ff) begin
         if (req.is_final && is_quote) begin
            // closing quote: bare end marker, open escape dropped
            clr       = 1'b1;
            res_kind  = RES_SINGLE;
            res_unit  = '0;
            res_valid = 1'b0;
         end else begin
            if (!in_escape_ff) begin
               if (cu == CHAR_BACKSLASH) begin
                  in_escape_in = 1'b1;
               end else begin
                  res_kind = RES_SINGLE;
               end
            end else if (cu == CHAR_BACKSLASH) begin
               clr      = 1'b1;
               res_kind = (escape_kind_ff != KIND_NONE) ? RES_ECHO : RES_SINGLE;
            end else if (cu == CHAR_U || cu == CHAR_X) begin
               if (escape_kind_ff != KIND_NONE || !cfg.unescape_unicode) begin
                  clr      = 1'b1;
                  res_kind = RES_ECHO;
               end else begin
                  escape_kind_in = (cu == CHAR_U) ? KIND_U : KIND_X;
               end
            end else if (is_hex) begin
               if (escape_kind_ff == KIND_NONE) begin
                  clr      = 1'b1;
                  res_kind = RES_ECHO;
               end else if (hex_done) begin
                  clr      = 1'b1;
                  res_kind = RES_SINGLE;
                  res_unit = {hex_value_ff[UNIT_WIDTH-RADIX_BITS-1:0], dval};
               end else begin
                  held_digits_in[held_count_ff] = cu[DIGIT_WIDTH-1:0];
                  held_count_in = held_count_ff + 2'd1;
                  hex_value_in  = {hex_value_ff[UNIT_WIDTH-RADIX_BITS-1:0], dval};
               end
            end else begin
               clr      = 1'b1;
               res_kind = (escape_kind_ff == KIND_NONE && is_quote) ? RES_SINGLE
                                                                    : RES_ECHO;
            end

            if (req.is_final) begin
               // unclosed string
               clr      = 1'b1;
               unframed = 1'b1;
               if (res_kind == RES_NONE) begin
                  res_kind  = RES_SINGLE;
                  res_unit  = '0;
                  res_valid = 1'b0;
               end
            end
         end
      end else begin
         res_kind = RES_SINGLE;
      end

      if (req.is_final) begin
         decode_mode_in = 1'b0;
      end
      if (clr) begin
         in_escape_in   = 1'b0;
         escape_kind_in = KIND_NONE;
         held_count_in  = '0;
         hex_value_in   = '0;
      end
   end

   assign push                   = accept && (res_kind != RES_NONE);
   assign push_desc.echo         = (res_kind == RES_ECHO);
   assign push_desc.held_count   = held_count_ff;
   assign push_desc.held_digits  = held_digits_ff;
   assign push_desc.unit         = res_unit;
   assign push_desc.unit_valid   = res_valid;
   assign push_desc.string_end   = req.is_final;
   assign push_desc.unframed     = unframed;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         in_escape_ff   <= 1'b0;
         escape_kind_ff <= KIND_NONE;
         held_count_ff  <= '0;
         hex_value_ff   <= '0;
      end else if (accept) begin
         decode_mode_ff <= decode_mode_in;
         in_escape_ff   <= in_escape_in;
         escape_kind_ff <= escape_kind_in;
         held_count_ff  <= held_count_in;
         hex_value_ff   <= hex_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_digits_ff <= held_digits_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_final_leaves_mode: assert property (@(posedge clock) disable iff (reset)
      accept && req.is_final |=> !decode_mode_ff)
      else $error("decode mode survived a final unit");
   a_no_kind_no_digits: assert property (@(posedge clock) disable iff (reset)
      escape_kind_ff == KIND_NONE |-> held_count_ff == 2'd0)
      else $error("digits held without an open hex escape");
   a_kind_needs_escape: assert property (@(posedge clock) disable iff (reset)
      escape_kind_ff != KIND_NONE |-> in_escape_ff)
      else $error("hex escape open outside an escape");
`endif

endmodule

// ===== rtl/qsu_queue.sv =====
// ----------------------------------------------------------------------------
// qsu_queue
// small show-ahead queue of result groups between front and back
// ----------------------------------------------------------------------------
module qsu_queue import qsu_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head_desc
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   desc_type               entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_WIDTH'(1))
      else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/qsu_back.sv =====
// ----------------------------------------------------------------------------
// qsu_back
// expands queued result groups into one result per cycle while the output is not stalled, behind an output reg
// ----------------------------------------------------------------------------
module qsu_back import qsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  desc_type    head_desc,
   output logic        pop,
   qsu_rsp_if.source   rsp
);

   localparam int IDX_WIDTH = $clog2(MAX_RESULTS);

   logic [IDX_WIDTH-1:0]  idx_ff, idx_in;
   logic                  rsp_valid_ff;
   logic [UNIT_WIDTH-1:0] out_unit_ff, out_unit_in;
   logic                  unit_valid_ff, unit_valid_in;
   logic                  run_end_ff, string_end_ff, unframed_ff;

   logic [IDX_WIDTH-1:0]  total;
   logic [IDX_WIDTH-1:0]  idx_m1;
   logic                  last;
   logic                  out_free;
   logic                  advance;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign advance  = out_free && head_valid;
   assign total    = head_desc.echo ? IDX_WIDTH'(head_desc.held_count) + IDX_WIDTH'(2)
                                    : IDX_WIDTH'(1);
   assign last     = (idx_ff == total - IDX_WIDTH'(1));
   assign idx_m1   = idx_ff - IDX_WIDTH'(1);
   assign pop      = advance && last;

   always_comb begin
      unit_valid_in = 1'b1;
      if (!head_desc.echo) begin
         out_unit_in   = head_desc.unit;
         unit_valid_in = head_desc.unit_valid;
      end else if (idx_ff == '0) begin
         out_unit_in = CHAR_BACKSLASH;
      end else if (last) begin
         out_unit_in = head_desc.unit;
      end else begin
         out_unit_in = UNIT_WIDTH'(head_desc.held_digits[idx_m1[1:0]]);
      end
      idx_in = last ? '0 : idx_ff + IDX_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= head_valid;
         end
         if (advance) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_unit_ff   <= out_unit_in;
         unit_valid_ff <= unit_valid_in;
         run_end_ff    <= last;
         string_end_ff <= last && head_desc.string_end;
         unframed_ff   <= last && head_desc.unframed;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_unit   = out_unit_ff;
   assign rsp.unit_valid = unit_valid_ff;
   assign rsp.run_end    = run_end_ff;
   assign rsp.string_end = string_end_ff;
   assign rsp.unframed   = unframed_ff;

endmodule

// ===== rtl/quoted_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// quoted_string_unescaper
// decodes backslash escapes in quoted UTF-16 strings, passes others through
// ----------------------------------------------------------------------------
// an accepted unit passes a queue entry and then the result register before its first result
// throughput: one unit per cycle while each gives one result and the output is
//   not stalled; a unit that gives n results holds the result register for each
//   of them in turn; the rate is set by the single result register in the back end
// reset clears framing and escape state, the queue and the output valid;
//   registers return to quote 0x22 and hex decoding off
module quoted_string_unescaper import qsu_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   qsu_req_if.sink   req,
   qsu_rsp_if.source rsp,
   qsu_csr_if.sink   csr
);

   // configuration registers; the user must write them only while idle, the block itself does not enforce it
   cfg_type  cfg_ff;

   // front to queue
   logic     push;
   desc_type push_desc;
   logic     queue_full;

   // queue to back
   logic     pop;
   logic     head_valid;
   desc_type head_desc;

   // register writes are always taken; unknown indexes are ignored
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quote_char       <= QUOTE_RESET;
         cfg_ff.unescape_unicode <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_QUOTE_CHAR: begin
               cfg_ff.quote_char <= csr.data[UNIT_WIDTH-1:0];
            end
            REG_UNESCAPE_UNICODE: begin
               cfg_ff.unescape_unicode <= csr.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // front: takes each transaction, updates escape state in the same cycle
   qsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_desc  (push_desc)
   );

   // queue of pending result groups lets the front run on while results wait
   qsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // back: one result transaction per cycle while the output is not stalled, flags on the last of a group
   qsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

// ===== tb/qsu_unescape_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qsu_unescape_check
// watches the unit, result and register channels, predicts the decoded units
// of every accepted transaction and compares them with the results in order
// ----------------------------------------------------------------------------
module qsu_unescape_check import qsu_pkg::*; (
   input  logic clock,
   input  logic reset,
   qsu_req_if   req,
   qsu_rsp_if   rsp,
   qsu_csr_if   csr,
   output int   error_total,
   output int   results_owed
);

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] out_unit;
      logic                  unit_valid;
      logic                  run_end;
      logic                  string_end;
      logic                  unframed;
   } decoded_unit_type;

   // register copies
   logic [UNIT_WIDTH-1:0]  quote_unit;
   logic                   hex_enable;

   // decoder state
   logic                   decoding;
   logic                   escaping;
   logic [1:0]             esc_kind;
   logic [DIGIT_WIDTH-1:0] held_digit [HELD_MAX];
   logic [1:0]             held_n;
   logic [UNIT_WIDTH-1:0]  hex_acc;

   decoded_unit_type       step_out [MAX_RESULTS];
   int                     step_n;
   decoded_unit_type       owed_units [$];
   decoded_unit_type       seen;
   decoded_unit_type       want;
   int                     mismatches;

   function automatic logic nibble_of(input logic [UNIT_WIDTH-1:0] ch,
                                      output logic [3:0] v);
      v = 4'h0;
      if (ch inside {[16'h0030:16'h0039]}) begin
         v = ch[3:0];
         return 1'b1;
      end
      if (ch inside {[16'h0041:16'h0046], [16'h0061:16'h0066]}) begin
         v = ch[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic put_out(input logic [UNIT_WIDTH-1:0] u, input logic v);
      if (step_n < MAX_RESULTS) begin
         step_out[step_n]            = '0;
         step_out[step_n].out_unit   = u;
         step_out[step_n].unit_valid = v;
         step_n++;
      end
   endtask

   task automatic drop_escape();
      escaping = 1'b0;
      esc_kind = KIND_NONE;
      held_n   = 2'd0;
      hex_acc  = '0;
   endtask

   // backslash, the digits held so far, then the unit that broke the escape
   task automatic echo_escape(input logic [UNIT_WIDTH-1:0] ch);
      put_out(CHAR_BACKSLASH, 1'b1);
      for (int i = 0; i < int'(held_n); i++) begin
         put_out({8'h00, held_digit[i]}, 1'b1);
      end
      put_out(ch, 1'b1);
      drop_escape();
   endtask

   task automatic decode_content(input logic [UNIT_WIDTH-1:0] ch);
      logic [3:0]            d;
      logic [UNIT_WIDTH-1:0] acc;
      int                    need;
      if (!escaping) begin
         if (ch == CHAR_BACKSLASH) begin
            escaping = 1'b1;
         end else begin
            put_out(ch, 1'b1);
         end
      end else if (ch == CHAR_BACKSLASH) begin
         if (esc_kind != KIND_NONE) begin
            echo_escape(ch);
         end else begin
            put_out(ch, 1'b1);
            drop_escape();
         end
      end else if (ch == CHAR_U || ch == CHAR_X) begin
         if (esc_kind != KIND_NONE || !hex_enable) begin
            echo_escape(ch);
         end else begin
            esc_kind = (ch == CHAR_U) ? KIND_U : KIND_X;
         end
      end else if (nibble_of(ch, d)) begin
         if (esc_kind == KIND_NONE) begin
            echo_escape(ch);
         end else begin
            need = (esc_kind == KIND_U) ? 4 : 2;
            acc  = {hex_acc[UNIT_WIDTH-5:0], d};
            if (int'(held_n) + 1 >= need) begin
               put_out(acc, 1'b1);
               drop_escape();
            end else begin
               held_digit[held_n] = ch[DIGIT_WIDTH-1:0];
               held_n++;
               hex_acc = acc;
            end
         end
      end else if (esc_kind == KIND_NONE && ch == quote_unit) begin
         put_out(ch, 1'b1);
         drop_escape();
      end else begin
         echo_escape(ch);
      end
   endtask

   task automatic unescape_step(input logic [UNIT_WIDTH-1:0] cu,
                                input logic first, input logic last);
      logic open_end;
      open_end = 1'b0;
      step_n   = 0;
      if (first) begin
         drop_escape();
         if (cu == quote_unit && !last) begin
            decoding = 1'b1;
         end else begin
            decoding = 1'b0;
            put_out(cu, 1'b1);
         end
      end else if (decoding) begin
         if (last && cu == quote_unit) begin
            drop_escape();
            put_out('0, 1'b0);
         end else begin
            decode_content(cu);
            if (last) begin
               drop_escape();
               if (step_n == 0) begin
                  put_out('0, 1'b0);
               end
               open_end = 1'b1;
            end
         end
      end else begin
         put_out(cu, 1'b1);
      end
      if (last) begin
         decoding = 1'b0;
      end
      if (step_n > 0) begin
         step_out[step_n-1].run_end = 1'b1;
         if (last) begin
            step_out[step_n-1].string_end = 1'b1;
            step_out[step_n-1].unframed   = open_end;
         end
      end
      for (int i = 0; i < step_n; i++) begin
         owed_units.push_back(step_out[i]);
      end
   endtask

   function automatic void compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         quote_unit = QUOTE_RESET;
         hex_enable = 1'b0;
         decoding   = 1'b0;
         for (int i = 0; i < HELD_MAX; i++) begin
            held_digit[i] = '0;
         end
         drop_escape();
         owed_units.delete();
         mismatches = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_QUOTE_CHAR:       quote_unit = csr.data[UNIT_WIDTH-1:0];
               REG_UNESCAPE_UNICODE: hex_enable = csr.data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            unescape_step(req.code_unit, req.is_first, req.is_final);
         end
         if (rsp.valid && rsp.ready) begin
            seen = '{rsp.out_unit, rsp.unit_valid, rsp.run_end, rsp.string_end, rsp.unframed};
            if (owed_units.size() == 0) begin
               $error("unexpected result: out_unit %0h unit_valid %0b", seen.out_unit,
                      seen.unit_valid);
               mismatches++;
            end else begin
               want = owed_units.pop_front();
               compare_field("out_unit", want.out_unit, seen.out_unit);
               compare_field("unit_valid", want.unit_valid, seen.unit_valid);
               compare_field("run_end", want.run_end, seen.run_end);
               compare_field("string_end", want.string_end, seen.string_end);
               compare_field("unframed", want.unframed, seen.unframed);
            end
         end
      end
      results_owed <= owed_units.size();
      error_total  <= mismatches;
   end

endmodule

// ===== tb/tb_quoted_string_unescaper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_string_unescaper
// drives framed and passthrough strings with random escapes through the
// unescaper under several register settings, with random stalls on both
// sides; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_quoted_string_unescaper;
   import qsu_pkg::*;

   localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction at all
   localparam int SETTLE_CYCLES = 8;     // covers the queue entry and result register with margin
   localparam int PHASES        = 9;
   localparam int PHASE_UNITS   = 22;

   typedef enum {TAIL_CLOSED, TAIL_UNCLOSED, TAIL_ABANDONED} string_tail_type;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] code_unit;
      logic                  is_first;
      logic                  is_final;
   } unit_item_type;

   logic clock;
   logic reset;
   int   fail_total;
   int   results_owed;

   qsu_req_if req_if();
   qsu_rsp_if rsp_if();
   qsu_csr_if csr_if();

   quoted_string_unescaper dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   qsu_unescape_check unescape_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr          (csr_if),
      .error_total  (fail_total),
      .results_owed (results_owed)
   );

   // register settings per random phase; the last quote is drawn at random
   logic [UNIT_WIDTH-1:0] phase_quote [PHASES] = '{16'h0022, 16'h0027, 16'h0000,
      16'hFFFF, CHAR_BACKSLASH, CHAR_U, CHAR_X, 16'h0041, 16'h0022};
   logic                  phase_hex   [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
      1'b1, 1'b0, 1'b1};

   logic [UNIT_WIDTH-1:0] cur_quote;
   logic [UNIT_WIDTH-1:0] body [$];       // content of the string being built
   unit_item_type         script_q [$];   // transactions waiting to be sent
   int                    units_sent;
   logic                  calm;           // no stalls on either side

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, a few long ones, none at all while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   // printable text, now and then any 16-bit unit; never a stray backslash
   function automatic logic [UNIT_WIDTH-1:0] plain_unit();
      logic [UNIT_WIDTH-1:0] u;
      if ($urandom_range(0, 6) == 0) begin
         u = UNIT_WIDTH'($urandom_range(0, 65535));
      end else begin
         u = UNIT_WIDTH'($urandom_range(32, 126));
      end
      if (u == CHAR_BACKSLASH) begin
         u = 16'h0061;
      end
      return u;
   endfunction

   function automatic logic [UNIT_WIDTH-1:0] hex_char();
      case ($urandom_range(0, 2))
         0:       return 16'h0030 + UNIT_WIDTH'($urandom_range(0, 9));
         1:       return 16'h0061 + UNIT_WIDTH'($urandom_range(0, 5));
         default: return 16'h0041 + UNIT_WIDTH'($urandom_range(0, 5));
      endcase
   endfunction

   // one piece of string content: a plain unit or an escape sequence,
   // hex escapes often cut short so the echo paths get exercised
   task automatic add_token();
      int n;
      if ($urandom_range(0, 99) < 55) begin
         body.push_back(plain_unit());
      end else begin
         body.push_back(CHAR_BACKSLASH);
         case ($urandom_range(0, 9))
            0: body.push_back(CHAR_BACKSLASH);
            1: body.push_back(cur_quote);
            2, 3: begin
               body.push_back(CHAR_U);
               n = $urandom_range(0, 4);
               repeat (n) body.push_back(hex_char());
            end
            4, 5: begin
               body.push_back(CHAR_X);
               n = $urandom_range(0, 2);
               repeat (n) body.push_back(hex_char());
            end
            6: body.push_back(hex_char());
            default: body.push_back(plain_unit());
         endcase
      end
   endtask

   task automatic queue_unit(input logic [UNIT_WIDTH-1:0] cu, input logic first,
                             input logic last);
      script_q.push_back('{cu, first, last});
   endtask

   // opening quote, the content, then the closing quote, a final content
   // unit, or nothing at all when the next string cuts this one off
   task automatic queue_quoted(input string_tail_type tail);
      queue_unit(cur_quote, 1'b1, 1'b0);
      foreach (body[i]) begin
         queue_unit(body[i], 1'b0, tail == TAIL_UNCLOSED && i == body.size() - 1);
      end
      if (tail == TAIL_CLOSED) begin
         queue_unit(cur_quote, 1'b0, 1'b1);
      end
      body.delete();
   endtask

   task automatic queue_plain();
      foreach (body[i]) begin
         queue_unit(body[i], i == 0, i == body.size() - 1);
      end
      body.delete();
   endtask

   // valid stays high across back-to-back transactions and only drops for a gap
   task automatic send_unit(input unit_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.code_unit <= it.code_unit;
      req_if.is_first  <= it.is_first;
      req_if.is_final  <= it.is_final;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_script();
      while (script_q.size() != 0) begin
         send_unit(script_q.pop_front());
         units_sent++;
      end
   endtask

   // hold the sender until every predicted result is in, then let units that
   // give no result drain out of the pipeline
   task automatic wait_results_done();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both registers back to back, only while the block is idle
   task automatic configure(input logic [UNIT_WIDTH-1:0] quote, input logic hex_on);
      csr_if.valid <= 1'b1;
      csr_if.index <= REG_QUOTE_CHAR;
      csr_if.data  <= CSR_DATA_WIDTH'(quote);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.index <= REG_UNESCAPE_UNICODE;
      csr_if.data  <= CSR_DATA_WIDTH'(hex_on);
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cur_quote = quote;
   endtask

   // result side back-pressure, independent of the sender
   initial begin : result_stall
      int gap;
      forever begin
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // ends the run if the channels go quiet for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int          p;
      int          n;
      int          r;
      int          target;
      logic [UNIT_WIDTH-1:0] q;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.code_unit <= '0;
      req_if.is_first  <= 1'b0;
      req_if.is_final  <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.data      <= '0;
      cur_quote  = QUOTE_RESET;
      units_sent = 0;
      calm       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, hex decoding on
      configure(QUOTE_RESET, 1'b1);
      // escaped quote and backslash, \x4F, \u123Z echoed as five units,
      // \7 echoed, and \uA still open at the closing quote
      body = '{CHAR_BACKSLASH, cur_quote, CHAR_BACKSLASH, CHAR_BACKSLASH,
               CHAR_BACKSLASH, CHAR_X, 16'h0034, 16'h0046,
               CHAR_BACKSLASH, CHAR_U, 16'h0031, 16'h0032, 16'h0033, 16'h005A,
               CHAR_BACKSLASH, 16'h0037, CHAR_BACKSLASH, CHAR_U, 16'h0041};
      queue_quoted(TAIL_CLOSED);
      // lone quote is a one-unit passthrough string
      queue_unit(cur_quote, 1'b1, 1'b1);
      // unclosed string whose final unit opens an escape: bare unframed marker
      body = '{16'h0062, CHAR_BACKSLASH};
      queue_quoted(TAIL_UNCLOSED);
      // unit after a final without a first flag
      queue_unit(16'hFFFF, 1'b0, 1'b1);
      // quoted string cut off by a new first unit
      queue_unit(cur_quote, 1'b1, 1'b0);
      queue_unit(16'h0064, 1'b0, 1'b0);
      queue_unit(16'h0000, 1'b1, 1'b1);
      send_script();
      wait_results_done();

      // random phases, one register setting each
      for (p = 0; p < PHASES; p++) begin
         q = phase_quote[p];
         if (p == PHASES - 1) begin
            q = UNIT_WIDTH'($urandom_range(32, 126));
         end
         configure(q, phase_hex[p]);
         calm   = (p % 4 == 2);
         target = units_sent + PHASE_UNITS;
         while (units_sent < target) begin
            r = $urandom_range(0, 99);
            body.delete();
            if (r < 78) begin
               // quoted string with random escapes, closed in most cases
               n = $urandom_range(1, 6);
               repeat (n) add_token();
               queue_quoted(($urandom_range(0, 9) < 8) ? TAIL_CLOSED : TAIL_UNCLOSED);
            end else if (r < 86) begin
               n = $urandom_range(1, 4);
               repeat (n) body.push_back(UNIT_WIDTH'($urandom_range(0, 65535)));
               queue_plain();
            end else if (r < 91) begin
               // stray units with no first flag
               n = $urandom_range(1, 3);
               for (int i = 0; i < n; i++) begin
                  queue_unit(UNIT_WIDTH'($urandom_range(0, 65535)), 1'b0,
                             i == n - 1 && $urandom_range(0, 1) == 1);
               end
            end else if (r < 95) begin
               n = $urandom_range(0, 3);
               repeat (n) add_token();
               queue_quoted(TAIL_ABANDONED);
            end else if (r < 98) begin
               queue_unit(cur_quote, 1'b1, 1'b1);
            end else begin
               // empty quoted string
               queue_quoted(TAIL_CLOSED);
            end
            send_script();
            // now and then the sender holds off until all results are in
            if ($urandom_range(0, 39) == 0) begin
               wait_results_done();
            end
         end
         wait_results_done();
      end

      if (fail_total == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
